// ===== rtl/swls_pkg.sv =====
// Shared constants and helpers for the sine wobble line shifter.
// Holds the sine table, effect mode codes and the damping ramp thresholds.
// Used by swls_shift_calc and sine_wobble_line_shifter; no dependencies.
package swls_pkg;

  localparam int LineBytesDef = 32;
  localparam int MaxBytes     = 32;
  localparam int LineW        = 8 * MaxBytes;

  localparam logic RegIdxEffectMode = 1'b0;

  localparam logic [3:0] ModeSmooth  = 4'd0;
  localparam logic [3:0] ModeRipple  = 4'd1;
  localparam logic [3:0] ModeOcean   = 4'd2;
  localparam logic [3:0] ModeShear   = 4'd3;
  localparam logic [3:0] ModeInterf  = 4'd4;
  localparam logic [3:0] ModeDampen  = 4'd5;
  localparam logic [3:0] ModeBreathe = 4'd6;
  localparam logic [3:0] ModeZigzag  = 4'd7;
  localparam logic [3:0] ModeCascade = 4'd8;

  localparam logic [2:0] WaveTab [32] = '{
    3'd4, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6,
    3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0,
    3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd5
  };

  localparam logic [6:0] DampT1 = 7'd20;
  localparam logic [6:0] DampT2 = 7'd40;
  localparam logic [6:0] DampT3 = 7'd55;
  localparam logic [6:0] DampT4 = 7'd70;
  localparam logic [6:0] DampT5 = 7'd85;
  localparam logic [6:0] DampT6 = 7'd100;
  localparam logic [6:0] DampT7 = 7'd115;

  function automatic logic [2:0] wave_raw(input logic [4:0] idx);
    return WaveTab[idx];
  endfunction

  function automatic logic signed [3:0] wave_at(input logic [4:0] idx);
    return $signed({1'b0, WaveTab[idx]}) - 4'sd4;
  endfunction

  function automatic logic [2:0] damp_amp(input logic [6:0] p);
    logic [2:0] a;
    if (p < DampT1) begin
      a = 3'd7;
    end else if (p < DampT2) begin
      a = 3'd6;
    end else if (p < DampT3) begin
      a = 3'd5;
    end else if (p < DampT4) begin
      a = 3'd4;
    end else if (p < DampT5) begin
      a = 3'd3;
    end else if (p < DampT6) begin
      a = 3'd2;
    end else if (p < DampT7) begin
      a = 3'd1;
    end else begin
      a = 3'd0;
    end
    return a;
  endfunction

  // truncate toward zero; |v| stays at or below 28
  function automatic logic signed [3:0] div7(input logic signed [5:0] v);
    logic [5:0] m;
    logic [2:0] q;
    m = v[5] ? 6'(-v) : 6'(v);
    if (m >= 6'd28) begin
      q = 3'd4;
    end else if (m >= 6'd21) begin
      q = 3'd3;
    end else if (m >= 6'd14) begin
      q = 3'd2;
    end else if (m >= 6'd7) begin
      q = 3'd1;
    end else begin
      q = 3'd0;
    end
    return v[5] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ===== rtl/swls_shift_calc.sv =====
// Shift amount for one scanline from frame number, line index and effect mode.
// Depends on swls_pkg for the sine table, mode codes and division helper.
module swls_shift_calc (
  input  logic        [3:0] mode_i,
  input  logic        [7:0] frame_i,
  input  logic        [3:0] line_i,
  output logic signed [3:0] shift_o
);

  logic        [4:0] f5;
  logic        [4:0] l5;
  logic signed [4:0] sh;
  logic signed [4:0] w_a;
  logic signed [4:0] w_b;
  logic signed [5:0] prod;

  assign f5 = frame_i[4:0];
  assign l5 = {1'b0, line_i};

  always_comb begin
    sh   = '0;
    w_a  = '0;
    w_b  = '0;
    prod = '0;
    case (mode_i)
      swls_pkg::ModeSmooth: begin
        sh = 5'(swls_pkg::wave_at(5'(f5 * 5'd2 + l5 * 5'd4)));
      end
      swls_pkg::ModeRipple: begin
        sh = 5'(swls_pkg::wave_at(5'(f5 * 5'd5 + l5 * 5'd8)));
      end
      swls_pkg::ModeOcean: begin
        sh = 5'(swls_pkg::wave_at(5'(f5 + l5 * 5'd2)));
      end
      swls_pkg::ModeShear: begin
        w_a = 5'(swls_pkg::wave_at(5'(f5 * 5'd3 + l5 * 5'd3)));
        sh  = line_i[3] ? -w_a : w_a;
      end
      swls_pkg::ModeInterf: begin
        w_a = 5'(swls_pkg::wave_at(5'(f5 * 5'd2 + l5 * 5'd3)));
        w_b = 5'(swls_pkg::wave_at(5'(f5 * 5'd3 + l5 * 5'd7)));
        sh  = (w_a + w_b) >>> 1;
      end
      swls_pkg::ModeDampen: begin
        w_a  = 5'(swls_pkg::wave_at(5'(f5 * 5'd4 + l5 * 5'd5)));
        prod = 6'(6'(w_a) * $signed({3'b000, swls_pkg::damp_amp(frame_i[6:0])}));
        sh   = 5'(swls_pkg::div7(prod));
      end
      swls_pkg::ModeBreathe: begin
        w_a  = 5'(swls_pkg::wave_at(5'(f5 * 5'd3 + l5 * 5'd4)));
        prod = 6'(6'(w_a) * $signed({3'b000, swls_pkg::wave_raw(frame_i[6:2])}));
        sh   = 5'(swls_pkg::div7(prod));
      end
      swls_pkg::ModeZigzag: begin
        w_a = 5'(swls_pkg::wave_at(5'(f5 * 5'd3 + l5 * 5'd4)));
        sh  = line_i[0] ? -w_a : w_a;
      end
      swls_pkg::ModeCascade: begin
        sh = 5'(swls_pkg::wave_at(5'(f5 * 5'd2 + l5 * 5'd12)));
      end
      default: begin
        sh = '0;
      end
    endcase
  end

  assign shift_o = sh[3:0];

endmodule

// ===== rtl/sine_wobble_line_shifter.sv =====
// Sine wobble line shifter top level: APB mode register, input and result registers.
// Depends on swls_pkg and swls_shift_calc.
// The start transfer passes through in_valid_q and then done_q, which drives the done_o strobe.
// Throughput: one line per cycle; busy is held low and results are never stalled.
// Reset clears the effect mode to smooth and drops all strobes.
module sine_wobble_line_shifter #(
  parameter int LINE_BYTES = swls_pkg::LineBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic        [7:0]  frame_number_i,
  input  logic        [3:0]  line_index_i,
  input  logic        [63:0] pixels_0_i,
  input  logic        [63:0] pixels_1_i,
  input  logic        [63:0] pixels_2_i,
  input  logic        [63:0] pixels_3_i,
  output logic               done_o,
  output logic        [63:0] shifted_0_o,
  output logic        [63:0] shifted_1_o,
  output logic        [63:0] shifted_2_o,
  output logic        [63:0] shifted_3_o,
  output logic signed [3:0]  shift_amount_o
);

  localparam int LineW    = swls_pkg::LineW;
  localparam int NumBytes = (LINE_BYTES > swls_pkg::MaxBytes) ? swls_pkg::MaxBytes
                                                               : LINE_BYTES;
  localparam logic [LineW-1:0] LineMask = {LineW{1'b1}} << (LineW - 8 * NumBytes);

  logic              [3:0]       mode_q;
  logic                          in_valid_q;
  logic              [7:0]       frame_q;
  logic              [3:0]       line_q;
  logic              [LineW-1:0] pix_q;
  logic                          done_q;
  logic              [LineW-1:0] shifted_q;
  logic              [LineW-1:0] shifted_d;
  logic signed       [3:0]       amt_q;
  logic signed       [3:0]       sh;
  logic              [2:0]       mag;
  logic              [LineW-1:0] lin;
  logic                          cfg_wr;
  logic                          accept;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == swls_pkg::RegIdxEffectMode) ? {28'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= swls_pkg::ModeSmooth;
    end else if (cfg_wr && paddr[2] == swls_pkg::RegIdxEffectMode) begin
      mode_q <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= accept;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_number_i;
      line_q  <= line_index_i;
      pix_q   <= {pixels_0_i, pixels_1_i, pixels_2_i, pixels_3_i};
    end
    if (in_valid_q) begin
      shifted_q <= shifted_d;
      amt_q     <= sh;
    end
  end

  swls_shift_calc u_calc (
    .mode_i  (mode_q),
    .frame_i (frame_q),
    .line_i  (line_q),
    .shift_o (sh)
  );

  assign mag       = sh[3] ? 3'(-sh) : sh[2:0];
  assign lin       = pix_q & LineMask;
  assign shifted_d = (sh[3] ? (lin << mag) : (lin >> mag)) & LineMask;

  assign done_o         = done_q;
  assign shifted_0_o    = shifted_q[255:192];
  assign shifted_1_o    = shifted_q[191:128];
  assign shifted_2_o    = shifted_q[127:64];
  assign shifted_3_o    = shifted_q[63:0];
  assign shift_amount_o = amt_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without a matching start transfer");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (shift_amount_o >= -4'sd4 && shift_amount_o <= 4'sd4))
    else $error("shift amount out of range");

  a_unused_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_q > swls_pkg::ModeCascade |-> shift_amount_o == 4'sd0)
    else $error("unused mode gave a non-zero shift");

  a_zero_shift_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && amt_q == 4'sd0 |-> shifted_q == ($past(pix_q) & LineMask))
    else $error("zero shift altered the line");

endmodule
